[src/pemenc_pkg.sv]
package pemenc_pkg;

	localparam int BEGIN_LEN = 28;
	localparam int END_LEN   = 26;
	localparam int QDEPTH    = 2;

	localparam logic [4:0] BEGIN_LAST = 5'(BEGIN_LEN - 1);
	localparam logic [4:0] END_LAST   = 5'(END_LEN - 1);

	localparam logic [8*BEGIN_LEN-1:0] BEGIN_STR = "-----BEGIN CERTIFICATE-----\n";
	localparam logic [8*END_LEN-1:0]   END_STR   = "-----END CERTIFICATE-----\n";

	localparam logic [6:0] CHAR_NL  = 7'h0A;
	localparam logic [6:0] CHAR_PAD = 7'h3D;

	// one queued word: characters of one input byte, already encoded
	typedef struct packed {
		logic            hdr;
		logic            last;
		logic [2:0]      cnt;
		logic [3:0][6:0] chars;
	} op_t;

	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] r;
		if (v < 6'd26) begin
			r = 7'h41 + {1'b0, v};
		end else if (v < 6'd52) begin
			r = 7'h61 + {1'b0, v} - 7'd26;
		end else if (v < 6'd62) begin
			r = 7'h30 + {1'b0, v} - 7'd52;
		end else if (v == 6'd62) begin
			r = 7'h2B;
		end else begin
			r = 7'h2F;
		end
		return r;
	endfunction

	function automatic logic [6:0] begin_char(input logic [4:0] i);
		logic [6:0] r;
		r = '0;
		if (i <= BEGIN_LAST) begin
			r = BEGIN_STR[8*(BEGIN_LEN-1-int'(i)) +: 7];
		end
		return r;
	endfunction

	function automatic logic [6:0] end_char(input logic [4:0] i);
		logic [6:0] r;
		r = '0;
		if (i <= END_LAST) begin
			r = END_STR[8*(END_LEN-1-int'(i)) +: 7];
		end
		return r;
	endfunction

endpackage

[src/pemenc_in_if.sv]
interface pemenc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

[src/pemenc_out_if.sv]
interface pemenc_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] text_char;
	logic       last_char;

	modport source(output valid, output text_char, output last_char, input ready);
	modport sink(input valid, input text_char, input last_char, output ready);
endinterface

[src/pemenc_front.sv]
module pemenc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output pemenc_pkg::op_t    op
);
	import pemenc_pkg::*;

	logic [1:0] phase_q;
	logic [3:0] carry_q;
	logic       hs_q;

	logic [1:0] phase_d;
	logic [3:0] carry_d;
	logic [5:0] s0;
	logic [5:0] s1;

	always_comb begin
		op      = '0;
		op.hdr  = ~hs_q;
		op.last = last_byte;
		s1      = '0;
		case (phase_q)
			2'd1: begin
				s0      = {carry_q[1:0], data_byte[7:4]};
				carry_d = data_byte[3:0];
				phase_d = 2'd2;
				if (last_byte) begin
					s1 = {carry_d, 2'b00};
					op.cnt = 3'd3;
					op.chars[2] = CHAR_PAD;
				end else begin
					op.cnt = 3'd1;
				end
			end
			2'd2: begin
				s0      = {carry_q, data_byte[7:6]};
				s1      = data_byte[5:0];
				carry_d = '0;
				phase_d = 2'd0;
				op.cnt  = 3'd2;
			end
			default: begin
				s0      = data_byte[7:2];
				carry_d = {2'b00, data_byte[1:0]};
				phase_d = 2'd1;
				if (last_byte) begin
					s1 = {carry_d[1:0], 4'b0000};
					op.cnt = 3'd4;
					op.chars[2] = CHAR_PAD;
					op.chars[3] = CHAR_PAD;
				end else begin
					op.cnt = 3'd1;
				end
			end
		endcase
		op.chars[0] = b64_char(s0);
		op.chars[1] = b64_char(s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			carry_q <= '0;
			hs_q    <= 1'b0;
		end else if (push) begin
			if (last_byte) begin
				phase_q <= '0;
				carry_q <= '0;
				hs_q    <= 1'b0;
			end else begin
				phase_q <= phase_d;
				carry_q <= carry_d;
				hs_q    <= 1'b1;
			end
		end
	end

endmodule

[src/pemenc_queue.sv]
module pemenc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pemenc_pkg::op_t    wr_op,
	input  logic               pop,
	output pemenc_pkg::op_t    head,
	output logic               full,
	output logic               empty
);
	import pemenc_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	op_t           mem_q [QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/pemenc_back.sv]
module pemenc_back #(
	parameter int LINE_CHARS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pemenc_pkg::op_t    head,
	input  logic               empty,
	output logic               pop,
	pemenc_out_if.source       text
);
	import pemenc_pkg::*;

	localparam int CW = $clog2(LINE_CHARS + 1);

	typedef enum logic [1:0] {ST_DATA, ST_NL, ST_TNL, ST_FTR} state_t;

	state_t        st_q, st_d;
	logic [4:0]    cnt_q, cnt_d;
	logic [CW-1:0] col_q, col_d, col_n;
	logic          hdr_q, hdr_d;
	logic          fin_q, fin_d;
	logic          ov_q;
	logic [6:0]    char_q;
	logic          lastc_q;

	logic          slot;
	logic          go;
	logic [6:0]    ch;
	logic          lc;
	logic          fin;

	assign slot = ~ov_q | text.ready;
	assign col_n = col_q + 1'b1;
	assign fin = (cnt_q[2:0] == head.cnt - 3'd1);

	always_comb begin
		st_d  = st_q;
		cnt_d = cnt_q;
		col_d = col_q;
		hdr_d = hdr_q;
		fin_d = fin_q;
		pop   = 1'b0;
		go    = 1'b0;
		ch    = CHAR_NL;
		lc    = 1'b0;
		if (slot) begin
			unique case (st_q)
				ST_DATA: begin
					if (!empty) begin
						go = 1'b1;
						if (head.hdr && !hdr_q) begin
							ch = begin_char(cnt_q);
							if (cnt_q == BEGIN_LAST) begin
								hdr_d = 1'b1;
								cnt_d = '0;
							end else begin
								cnt_d = cnt_q + 1'b1;
							end
						end else begin
							ch = head.chars[cnt_q[1:0]];
							if (col_n >= CW'(LINE_CHARS)) begin
								col_d = '0;
								st_d  = ST_NL;
								fin_d = fin;
								cnt_d = cnt_q + 1'b1;
							end else begin
								col_d = col_n;
								if (fin) begin
									cnt_d = '0;
									if (head.last) begin
										// line is open: newline before footer
										st_d = ST_TNL;
									end else begin
										pop   = 1'b1;
										hdr_d = 1'b0;
									end
								end else begin
									cnt_d = cnt_q + 1'b1;
								end
							end
						end
					end
				end
				ST_NL: begin
					go = 1'b1;
					if (fin_q) begin
						cnt_d = '0;
						if (head.last) begin
							st_d = ST_FTR;
						end else begin
							pop   = 1'b1;
							hdr_d = 1'b0;
							st_d  = ST_DATA;
						end
					end else begin
						st_d = ST_DATA;
					end
				end
				ST_TNL: begin
					go    = 1'b1;
					st_d  = ST_FTR;
					cnt_d = '0;
				end
				ST_FTR: begin
					go = 1'b1;
					ch = end_char(cnt_q);
					if (cnt_q == END_LAST) begin
						lc    = 1'b1;
						pop   = 1'b1;
						st_d  = ST_DATA;
						cnt_d = '0;
						hdr_d = 1'b0;
						col_d = '0;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
				default: begin
					st_d = ST_DATA;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_DATA;
			cnt_q   <= '0;
			col_q   <= '0;
			hdr_q   <= 1'b0;
			fin_q   <= 1'b0;
			ov_q    <= 1'b0;
			char_q  <= '0;
			lastc_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			col_q <= col_d;
			hdr_q <= hdr_d;
			fin_q <= fin_d;
			if (slot) begin
				ov_q <= go;
			end
			if (go) begin
				char_q  <= ch;
				lastc_q <= lc;
			end
		end
	end

	assign text.valid     = ov_q;
	assign text.text_char = char_q;
	assign text.last_char = lastc_q;

endmodule

[src/pem_base64_certificate_encoder.sv]
// With the queue empty, an accepted word is first written into the queue, then its first
// character is loaded into the output register, from which it can leave.
// Throughput: one character per cycle from the output register while the sink is ready; a
// byte gives about 1.33 characters in steady state, plus one newline per line wrap and the
// 28/26-character BEGIN/END lines, all through the single character output port.
// Reset: arst_n clears the encoder state, the queue and the output register.
module pem_base64_certificate_encoder #(
	parameter int LINE_CHARS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	pemenc_in_if.sink     data,
	pemenc_out_if.source  text
);
	import pemenc_pkg::*;

	op_t  wr_op;
	op_t  head;
	logic push;
	logic pop;
	logic full;
	logic empty;

	assign data.ready = ~full;
	assign push       = data.valid & ~full;

	pemenc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data.data_byte),
		.last_byte (data.last_byte),
		.op        (wr_op)
	);

	pemenc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_op  (wr_op),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	pemenc_back #(
		.LINE_CHARS (LINE_CHARS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.text   (text)
	);

endmodule

[src/pemenc_checker.sv]
module pemenc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] out_char,
	input logic       out_last
);
	import pemenc_pkg::*;

	logic [3:0] pend_q;
	logic       in_end;
	logic       out_end;

	assign in_end  = in_valid & in_ready & in_last;
	assign out_end = out_valid & out_ready & out_last;

	// certificates whose footer has not yet left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_end && !out_end) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_end && !in_end) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("output word changed while stalled");

	a_last_nl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_char == CHAR_NL)
		else $error("last_char on a character other than newline");

	a_footer_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_end |-> pend_q != '0)
		else $error("footer end without a last byte taken");

	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char == CHAR_NL) || (out_char >= 7'h20 && out_char != 7'h7F))
		else $error("non-printable character emitted");

endmodule

bind pem_base64_certificate_encoder pemenc_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (data.valid),
	.in_ready  (data.ready),
	.in_last   (data.last_byte),
	.out_valid (text.valid),
	.out_ready (text.ready),
	.out_char  (text.text_char),
	.out_last  (text.last_char)
);

[tb/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_CHARS  = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 24;
	localparam int RANDOM_BYTES = 167;
	localparam int IDLE_PCT     = 28;

	localparam logic [6:0] NEWLINE  = 7'h0A;
	localparam logic [6:0] PAD_CHAR = 7'h3D;

	typedef struct packed {
		logic [6:0] ch;
		logic       fin;
	} pem_char_t;

	class pem_text_checker;
		string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		string begin_text = "-----BEGIN CERTIFICATE-----\n";
		string end_text = "-----END CERTIFICATE-----\n";
		pem_char_t expected_chars[$];
		logic [1:0] phase;
		logic [3:0] carry;
		logic [6:0] column;
		bit header_done;
		int errors;

		function new();
			clear_state();
			errors = 0;
		endfunction

		function void clear_state();
			phase = '0;
			carry = '0;
			column = '0;
			header_done = 0;
		endfunction

		function void push_char(logic [6:0] c, logic f);
			pem_char_t e;
			e.ch = c;
			e.fin = f;
			expected_chars.insert(expected_chars.size(), e);
		endfunction

		// padding counts toward the line length like any data character
		function void push_data(logic [6:0] c);
			push_char(c, 1'b0);
			column = column + 7'd1;
			if (column >= LINE_CHARS) begin
				push_char(NEWLINE, 1'b0);
				column = '0;
			end
		endfunction

		function void push_sextet(logic [5:0] v);
			push_data(7'(alphabet[v]));
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			if (!header_done) begin
				for (int i = 0; i < begin_text.len(); i++)
					push_char(7'(begin_text[i]), 1'b0);
				header_done = 1;
				column = '0;
			end
			case (phase)
				2'd1: begin
					push_sextet({carry[1:0], b[7:4]});
					carry = b[3:0];
					phase = 2'd2;
				end
				2'd2: begin
					push_sextet({carry[3:0], b[7:6]});
					push_sextet(b[5:0]);
					carry = '0;
					phase = 2'd0;
				end
				default: begin
					push_sextet(b[7:2]);
					carry = {2'b00, b[1:0]};
					phase = 2'd1;
				end
			endcase
			if (last) begin
				if (phase == 2'd1) begin
					push_sextet({carry[1:0], 4'b0000});
					push_data(PAD_CHAR);
					push_data(PAD_CHAR);
				end else if (phase == 2'd2) begin
					push_sextet({carry, 2'b00});
					push_data(PAD_CHAR);
				end
				if (column != 0)
					push_char(NEWLINE, 1'b0);
				for (int i = 0; i < end_text.len(); i++)
					push_char(7'(end_text[i]), i == end_text.len() - 1);
				clear_state();
			end
		endfunction

		function void check_char(logic [6:0] c, logic f);
			pem_char_t e;
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected char: expected none, got text_char=%h last_char=%b",
					$time, c, f);
				errors++;
				return;
			end
			e = expected_chars.pop_front();
			if (c !== e.ch) begin
				$display("%0t: text_char mismatch: expected %h, got %h", $time, e.ch, c);
				errors++;
			end
			if (f !== e.fin) begin
				$display("%0t: last_char mismatch: expected %b, got %b", $time, e.fin, f);
				errors++;
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit calm;
	int cycles = 0;
	pem_text_checker sb = new();

	pemenc_in_if  byte_ch();
	pemenc_out_if text_ch();

	pem_base64_certificate_encoder #(
		.LINE_CHARS(LINE_CHARS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.data(byte_ch),
		.text(text_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// sink side: check accepted characters, then pick next ready
	always @(posedge clk) begin
		if (arst_n && text_ch.valid && text_ch.ready)
			sb.check_char(text_ch.text_char, text_ch.last_char);
		text_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last_byte <= last;
		do @(posedge clk); while (!byte_ch.ready);
		sb.note_byte(b, last);
	endtask

	task automatic send_cert(input int len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), i == len - 1);
	endtask

	initial begin
		int sent;
		int len;
		calm = 0;
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		byte_ch.last_byte <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte certificate: two chars plus double pad
		send_byte(8'h00, 1'b1);
		// two bytes: single pad
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		// whole group, no padding; hits '+' and '/'
		send_byte(8'hF8, 1'b0);
		send_byte(8'h0F, 1'b0);
		send_byte(8'hBF, 1'b1);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBE, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h55, 1'b1);
		// 48 bytes end exactly on a line wrap, so no extra newline
		send_cert(48);

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			case ($urandom_range(0, 4))
				0: len = $urandom_range(1, 6);
				1, 2: len = $urandom_range(7, 30);
				3: len = $urandom_range(44, 52);
				default: len = $urandom_range(90, 100);
			endcase
			if (len > RANDOM_BYTES - sent)
				len = RANDOM_BYTES - sent;
			calm = (sent >= 70 && sent < 140);
			send_cert(len);
			sent += len;
		end
		calm = 0;
		byte_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

[files.f]
src/pemenc_pkg.sv
src/pemenc_in_if.sv
src/pemenc_out_if.sv
src/pemenc_front.sv
src/pemenc_queue.sv
src/pemenc_back.sv
src/pem_base64_certificate_encoder.sv
src/pemenc_checker.sv
tb/testbench.sv
